// ===== rtl/can_tx_slot_queue_top_assert.svh =====
// Assertion macros shared by the checker of the CAN transmit slot queue.
`ifndef CAN_TX_SLOT_QUEUE_TOP_ASSERT_SVH
`define CAN_TX_SLOT_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SLQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SLQ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/slq_pkg.sv =====
// Shared types and codes of the CAN transmit slot queue.
package slq_pkg;

	localparam int MODE_W    = 2;
	localparam int EP_W      = 6;
	localparam int MSLOT_W   = 5;
	localparam int ID_W      = 11;
	localparam int LEN_W     = 4;
	localparam int DATA_W    = 64;
	localparam int CFG_W     = 5;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	// Request modes.
	localparam logic [MODE_W-1:0] MODE_MAP  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FULL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DATA = 2'd2;
	localparam logic [MODE_W-1:0] MODE_DONE = 2'd3;

	// Slot phases.
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_PENDING = 2'd1;
	localparam logic [1:0] PH_SENT    = 2'd2;

	// Transmit buffers.
	localparam logic BUF_IMM   = 1'b0;
	localparam logic BUF_QUEUE = 1'b1;

	// Register indexes.
	localparam logic REG_SLOTS_IN_USE = 1'b0;

	// A classified request as it travels from the front end to the back end.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              mapped;
		logic [ID_W-1:0]   can_id;
		logic              bus_sel;
		logic [LEN_W-1:0]  length;
		logic [DATA_W-1:0] payload;
		logic              buffer_ready;
	} cmd_t;

	// One result.
	typedef struct packed {
		logic              accepted;
		logic              send_valid;
		logic              send_buffer;
		logic [ID_W-1:0]   send_id;
		logic              send_bus;
		logic [LEN_W-1:0]  send_length;
		logic [DATA_W-1:0] send_data;
	} res_t;

endpackage

// ===== rtl/slq_cmd_if.sv =====
// Request channel of the CAN transmit slot queue.
interface slq_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [slq_pkg::MODE_W-1:0]  mode;
	logic [slq_pkg::EP_W-1:0]    endpoint;
	logic [slq_pkg::MSLOT_W-1:0] map_slot;
	logic [slq_pkg::ID_W-1:0]    can_id;
	logic                        bus_sel;
	logic [slq_pkg::LEN_W-1:0]   length;
	logic [slq_pkg::DATA_W-1:0]  payload;
	logic                        buffer_ready;

	modport source (output valid, mode, endpoint, map_slot, can_id, bus_sel, length, payload,
		buffer_ready, input ready);
	modport sink (input valid, mode, endpoint, map_slot, can_id, bus_sel, length, payload,
		buffer_ready, output ready);
endinterface

// ===== rtl/slq_rsp_if.sv =====
// Result channel of the CAN transmit slot queue.
interface slq_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       accepted;
	logic                       send_valid;
	logic                       send_buffer;
	logic [slq_pkg::ID_W-1:0]   send_id;
	logic                       send_bus;
	logic [slq_pkg::LEN_W-1:0]  send_length;
	logic [slq_pkg::DATA_W-1:0] send_data;

	modport source (output valid, accepted, send_valid, send_buffer, send_id, send_bus,
		send_length, send_data, input ready);
	modport sink (input valid, accepted, send_valid, send_buffer, send_id, send_bus,
		send_length, send_data, output ready);
endinterface

// ===== rtl/slq_front.sv =====
// Front end: accepts requests, keeps the endpoint map and classifies each request.
module slq_front #(
	parameter int ENDPOINT_COUNT = 64,
	parameter int SLOT_COUNT     = 16,
	parameter int SW             = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	slq_cmd_if.sink             cmd,
	output logic                push_valid,
	input  logic                push_ready,
	output slq_pkg::cmd_t       push_cmd,
	output logic [SW-1:0]       push_slot
);
	localparam int EPW = (ENDPOINT_COUNT > 1) ? $clog2(ENDPOINT_COUNT) : 1;
	localparam int EXW = (EPW > slq_pkg::EP_W) ? EPW : slq_pkg::EP_W;
	localparam int SXW = (SW > slq_pkg::MSLOT_W) ? SW : slq_pkg::MSLOT_W;

	// Map entry: top bit set when the endpoint points at a real slot.
	logic [SW:0]               map_mem [ENDPOINT_COUNT];
	logic [ENDPOINT_COUNT-1:0] map_vld_q;

	logic                      vld_s1;
	slq_pkg::cmd_t             cmd_s1;
	logic                      ep_ok_s1;
	logic                      map_vld_s1;
	logic [SW:0]               map_rd_s1;

	logic           accept;
	logic [EXW-1:0] ep_ext;
	logic [EPW-1:0] ep_idx;
	logic           ep_ok;
	logic [SXW-1:0] ms_ext;
	logic           ms_ok;
	logic           map_wr;

	assign accept = cmd.valid && cmd.ready;
	assign ep_ext = EXW'(cmd.endpoint);
	assign ep_idx = ep_ext[EPW-1:0];
	assign ep_ok  = int'(cmd.endpoint) < ENDPOINT_COUNT;
	assign ms_ext = SXW'(cmd.map_slot);
	assign ms_ok  = int'(cmd.map_slot) < SLOT_COUNT;
	assign map_wr = accept && (cmd.mode == slq_pkg::MODE_MAP) && ep_ok;

	assign cmd.ready  = !vld_s1 || push_ready;
	assign push_valid = vld_s1;

	always_comb begin
		push_cmd        = cmd_s1;
		push_cmd.mapped = ep_ok_s1 && map_vld_s1 && map_rd_s1[SW];
		push_slot       = map_rd_s1[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			map_vld_q <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (push_ready) begin
				vld_s1 <= 1'b0;
			end
			if (map_wr) begin
				map_vld_q[ep_idx] <= 1'b1;
			end
		end
	end

	// The lookup reads the entry before a map write of the same request lands.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.mode         <= cmd.mode;
			cmd_s1.mapped       <= 1'b0;
			cmd_s1.can_id       <= cmd.can_id;
			cmd_s1.bus_sel      <= cmd.bus_sel;
			cmd_s1.length       <= cmd.length;
			cmd_s1.payload      <= cmd.payload;
			cmd_s1.buffer_ready <= cmd.buffer_ready;
			ep_ok_s1            <= ep_ok;
			map_vld_s1          <= map_vld_q[ep_idx];
			map_rd_s1           <= map_mem[ep_idx];
		end
		if (map_wr) begin
			map_mem[ep_idx] <= {ms_ok, ms_ext[SW-1:0]};
		end
	end

endmodule

// ===== rtl/slq_fifo.sv =====
// Small register queue between the front end and the back end.
module slq_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign wr_ready = count_q != CW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/slq_back.sv =====
// Back end: slot store, phases, busy flag, transmit-done scan and the result register.
module slq_back #(
	parameter int SLOT_COUNT = 16,
	parameter int SW         = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_pop,
	input  slq_pkg::cmd_t               q_cmd,
	input  logic [SW-1:0]               q_slot,
	input  logic [slq_pkg::CFG_W-1:0]   slots_in_use,
	output logic                        res_valid,
	input  logic                        res_ready,
	output slq_pkg::res_t               res
);
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int IBW = slq_pkg::ID_W + 1;
	localparam int DBW = slq_pkg::LEN_W + slq_pkg::DATA_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FRAME = 2'd2;

	logic [1:0]            state_q;
	logic                  busy_q;
	logic [1:0]            phase_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] id_vld_q;
	logic [CW-1:0]         scan_q;
	logic                  out_valid_q;
	slq_pkg::res_t         out_q;

	// Slot store: {bus, identifier} and {length, payload}.
	logic [IBW-1:0] ident_mem [SLOT_COUNT];
	logic [DBW-1:0] data_mem [SLOT_COUNT];
	logic [IBW-1:0] id_rd_q;
	logic [DBW-1:0] data_rd_q;
	logic           id_vld_rd_q;

	slq_pkg::cmd_t  cur_q;
	logic           buf_q;

	logic           out_free;
	logic [CW-1:0]  lim;
	logic           scan_live;
	logic           scan_hit;
	logic           pop;
	logic           is_write;
	logic           wr_go;
	logic           send_now;
	logic           hit_go;
	logic           load;
	logic [SW-1:0]  rd_addr;
	slq_pkg::res_t  res_next;
	logic [IBW-1:0] frame_ib;

	assign out_free  = !out_valid_q || res_ready;
	assign lim       = (int'(slots_in_use) < SLOT_COUNT) ? CW'(slots_in_use) : CW'(SLOT_COUNT);
	assign scan_live = scan_q < lim;
	assign scan_hit  = scan_live && (phase_q[scan_q[SW-1:0]] == slq_pkg::PH_PENDING);
	assign pop       = (state_q == ST_IDLE) && q_valid && out_free;
	assign is_write  = (q_cmd.mode == slq_pkg::MODE_FULL) || (q_cmd.mode == slq_pkg::MODE_DATA);
	assign wr_go     = pop && is_write && q_cmd.mapped;
	assign send_now  = wr_go && !busy_q && q_cmd.buffer_ready;
	assign hit_go    = (state_q == ST_SCAN) && scan_hit;
	assign rd_addr   = (state_q == ST_SCAN) ? scan_q[SW-1:0] : q_slot;
	assign q_pop     = pop;

	assign load = (pop && !send_now && (q_cmd.mode != slq_pkg::MODE_DONE))
		|| ((state_q == ST_SCAN) && !scan_live && out_free)
		|| ((state_q == ST_FRAME) && out_free);

	always_comb begin
		res_next = '0;
		frame_ib = id_vld_rd_q ? id_rd_q : '0;
		if ((buf_q == slq_pkg::BUF_IMM) && (cur_q.mode == slq_pkg::MODE_FULL)) begin
			frame_ib = {cur_q.bus_sel, cur_q.can_id};
		end
		if (state_q == ST_FRAME) begin
			res_next.accepted    = (buf_q == slq_pkg::BUF_IMM);
			res_next.send_valid  = 1'b1;
			res_next.send_buffer = buf_q;
			res_next.send_bus    = frame_ib[IBW-1];
			res_next.send_id     = frame_ib[slq_pkg::ID_W-1:0];
			if (buf_q == slq_pkg::BUF_IMM) begin
				res_next.send_length = cur_q.length;
				res_next.send_data   = cur_q.payload;
			end else begin
				res_next.send_length = data_rd_q[DBW-1:slq_pkg::DATA_W];
				res_next.send_data   = data_rd_q[slq_pkg::DATA_W-1:0];
			end
		end else if (state_q == ST_IDLE) begin
			res_next.accepted = wr_go;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= 1'b0;
			id_vld_q    <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				phase_q[i] <= slq_pkg::PH_IDLE;
			end
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && (q_cmd.mode == slq_pkg::MODE_DONE)) begin
						busy_q  <= 1'b0;
						scan_q  <= '0;
						state_q <= ST_SCAN;
					end
					if (wr_go) begin
						phase_q[q_slot] <= send_now ? slq_pkg::PH_SENT : slq_pkg::PH_PENDING;
						if (q_cmd.mode == slq_pkg::MODE_FULL) begin
							id_vld_q[q_slot] <= 1'b1;
						end
					end
					if (send_now) begin
						state_q <= ST_FRAME;
					end
				end
				ST_SCAN: begin
					if (hit_go) begin
						phase_q[scan_q[SW-1:0]] <= slq_pkg::PH_SENT;
						busy_q                  <= 1'b1;
						state_q                 <= ST_FRAME;
					end else if (scan_live) begin
						scan_q <= scan_q + 1'b1;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FRAME: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_cmd;
			buf_q <= slq_pkg::BUF_IMM;
		end else if (hit_go) begin
			buf_q <= slq_pkg::BUF_QUEUE;
		end
		if (load) begin
			out_q <= res_next;
		end
	end

	// Slot store; reads return the contents from before a same-cycle write.
	always_ff @(posedge clk) begin
		if (wr_go && (q_cmd.mode == slq_pkg::MODE_FULL)) begin
			ident_mem[q_slot] <= {q_cmd.bus_sel, q_cmd.can_id};
		end
		if (wr_go) begin
			data_mem[q_slot] <= {q_cmd.length, q_cmd.payload};
		end
		id_rd_q     <= ident_mem[rd_addr];
		data_rd_q   <= data_mem[rd_addr];
		id_vld_rd_q <= id_vld_q[rd_addr];
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ===== rtl/can_tx_slot_queue_top.sv =====
// Top level of the CAN transmit slot queue: front end, request queue, back end, register.
//
// Requests arrive on the cmd channel (valid/ready); each request yields exactly one
// result on the rsp channel, in request order. Mode 0 maps an endpoint onto a slot,
// modes 1 and 2 write a message (full, or payload with the stored identifier and bus),
// mode 3 reports transmit done and hands the lowest pending slot below slots_in_use to the queue buffer.
// The slots_in_use register sits at byte address 0 of the APB port; pready is tied high.
// A write goes straight to the immediate buffer while busy is clear and buffer_ready is
// set. The back end takes one map or plain write per cycle while the result register is
// free; an immediate send or a transmit-done request holds it until its result is loaded,
// and the scan over slot phases goes one slot per cycle until it finds a pending slot or
// reaches the limit set by slots_in_use.
// The front end takes a request per cycle and a two-entry queue lets it run ahead
// while a result waits. When the rsp receiver stalls, the result register holds and
// the back end stops; the front end keeps taking requests until the queue fills.
// Reset clears the endpoint map to unmapped, all slot phases to idle, busy and the
// register; slot identifiers read as zero until written by a full-message write.
module can_tx_slot_queue_top #(
	parameter int SLOT_COUNT     = 16,
	parameter int ENDPOINT_COUNT = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	slq_cmd_if.sink                      cmd,
	slq_rsp_if.source                    rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [slq_pkg::APB_AW-1:0]   paddr,
	input  logic [slq_pkg::APB_DW-1:0]   pwdata,
	output logic [slq_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);
	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int QW = $bits(slq_pkg::cmd_t) + SW;

	logic [slq_pkg::CFG_W-1:0] slots_in_use_q;

	logic          push_valid;
	logic          push_ready;
	slq_pkg::cmd_t push_cmd;
	logic [SW-1:0] push_slot;

	logic          q_valid;
	logic          q_pop;
	logic [QW-1:0] q_data;
	slq_pkg::cmd_t q_cmd;
	logic [SW-1:0] q_slot;

	slq_pkg::res_t res;
	logic          reg_sel;

	// Register file: only slots_in_use; the word index is address bit 2.
	assign pready  = 1'b1;
	assign reg_sel = paddr[2] == slq_pkg::REG_SLOTS_IN_USE;
	assign prdata  = reg_sel ? slq_pkg::APB_DW'(slots_in_use_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			slots_in_use_q <= pwdata[slq_pkg::CFG_W-1:0];
		end
	end

	slq_front #(
		.ENDPOINT_COUNT (ENDPOINT_COUNT),
		.SLOT_COUNT     (SLOT_COUNT),
		.SW             (SW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.push_slot  (push_slot)
	);

	slq_fifo #(
		.W     (QW),
		.DEPTH (2)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  ({push_cmd, push_slot}),
		.rd_valid (q_valid),
		.rd_ready (q_pop),
		.rd_data  (q_data)
	);

	assign q_cmd  = q_data[QW-1:SW];
	assign q_slot = q_data[SW-1:0];

	slq_back #(
		.SLOT_COUNT (SLOT_COUNT),
		.SW         (SW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_cmd        (q_cmd),
		.q_slot       (q_slot),
		.slots_in_use (slots_in_use_q),
		.res_valid    (rsp.valid),
		.res_ready    (rsp.ready),
		.res          (res)
	);

	assign rsp.accepted    = res.accepted;
	assign rsp.send_valid  = res.send_valid;
	assign rsp.send_buffer = res.send_buffer;
	assign rsp.send_id     = res.send_id;
	assign rsp.send_bus    = res.send_bus;
	assign rsp.send_length = res.send_length;
	assign rsp.send_data   = res.send_data;

endmodule

// ===== rtl/slq_checker.sv =====
// Port-level checker of the CAN transmit slot queue and its bind.
`include "can_tx_slot_queue_top_assert.svh"

module slq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       accepted,
	input logic                       send_valid,
	input logic                       send_buffer,
	input logic [slq_pkg::ID_W-1:0]   send_id,
	input logic                       send_bus,
	input logic [slq_pkg::LEN_W-1:0]  send_length,
	input logic [slq_pkg::DATA_W-1:0] send_data
);

	`SLQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

	`SLQ_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(send_data) && $stable(send_id) && $stable(accepted), "result changed while stalled")

	`SLQ_ASSERT(a_no_frame_zero, rsp_valid && !send_valid |-> send_buffer == 1'b0 && send_id == '0 && send_bus == 1'b0 && send_length == '0 && send_data == '0, "frame fields set without a frame")

	`SLQ_ASSERT(a_buffer_accept, rsp_valid && send_valid |-> (send_buffer == slq_pkg::BUF_IMM) == accepted, "buffer choice disagrees with write acceptance")

endmodule

bind can_tx_slot_queue_top slq_checker u_slq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.accepted    (rsp.accepted),
	.send_valid  (rsp.send_valid),
	.send_buffer (rsp.send_buffer),
	.send_id     (rsp.send_id),
	.send_bus    (rsp.send_bus),
	.send_length (rsp.send_length),
	.send_data   (rsp.send_data)
);
